// ----- rtl/bitmap_range_allocator_core_macros.svh -----
// Assertion helpers used by the allocator controller.
`ifndef BITMAP_RANGE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_RANGE_ALLOCATOR_CORE_MACROS_SVH

// cond must hold at every clock edge outside reset
`define BRA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// when ante holds, cons must hold in the next cycle
`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bra_pkg.sv -----
package bra_pkg;

    localparam logic [2:0] REQ_MARK_USED = 3'd0;
    localparam logic [2:0] REQ_MARK_FREE = 3'd1;
    localparam logic [2:0] REQ_TEST      = 3'd2;
    localparam logic [2:0] REQ_FIRST     = 3'd3;
    localparam logic [2:0] REQ_RUN       = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_CONFLICT = 2'd2;

    localparam logic [12:0] BITS_IN_USE_RESET = 13'd4096;

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b0000_0000_0001,
        S_IDLE     = 12'b0000_0000_0010,
        S_DISPATCH = 12'b0000_0000_0100,
        S_TST_RD   = 12'b0000_0000_1000,
        S_CHK_RD   = 12'b0000_0001_0000,
        S_CHK_EV   = 12'b0000_0010_0000,
        S_WR_RD    = 12'b0000_0100_0000,
        S_WR_EV    = 12'b0000_1000_0000,
        S_SRCH_RD  = 12'b0001_0000_0000,
        S_SRCH_LD  = 12'b0010_0000_0000,
        S_SCAN     = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_TEST   = 2'd1,
        MODE_SEARCH = 2'd2
    } res_mode_t;

    typedef struct packed {
        logic      load_req;
        logic      rd_en;
        logic      wr_en;
        logic      wr_clear;
        logic      addr_zero;
        logic      addr_lo;
        logic      addr_inc;
        logic      shift_load;
        logic      scan_step;
        logic      set_found;
        logic      res_load;
        logic [1:0] res_status;
        res_mode_t res_mode;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       range_bad;
        logic       len_zero;
        logic       test_in;
        logic       too_long;
        logic       last_word;
        logic       clear_last;
        logic       conflict;
        logic       scan_hit;
        logic       scan_end;
        logic       word_end;
    } sts_t;

endpackage

// ----- rtl/bra_datapath.sv -----
module bra_datapath #(
    parameter int MAP_BITS = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bra_pkg::cmd_t   cmd,
    output bra_pkg::sts_t   sts,
    input  logic [12:0]     bits_in_use,
    input  logic [2:0]      req_type,
    input  logic [11:0]     start_index,
    input  logic [12:0]     run_length,
    output logic [1:0]      status,
    output logic            found,
    output logic [11:0]     found_index,
    output logic            bit_value
);

    localparam int WORDS = (MAP_BITS + 63) / 64;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SW0   = $clog2(MAP_BITS + 1) + 1;
    localparam int SW    = (SW0 > AW + 7) ? SW0 : AW + 7;

    logic [63:0]    mem [WORDS];
    logic [63:0]    rdata_reg;
    logic [AW-1:0]  waddr_reg;
    logic [2:0]     req_reg;
    logic [11:0]    start_reg;
    logic [12:0]    len_reg;
    logic [63:0]    shift_reg;
    logic [SW-1:0]  pos_reg;
    logic [12:0]    run_reg;
    logic           found_int_reg;
    logic [11:0]    fidx_int_reg;
    logic [1:0]     status_reg;
    logic           found_reg;
    logic [11:0]    fidx_reg;
    logic           bit_reg;

    logic [SW-1:0]  size;
    logic [SW-1:0]  biu_ext;
    logic [SW-1:0]  start_ext;
    logic [SW-1:0]  len_ext;
    logic [SW-1:0]  end_sum;
    logic [SW-1:0]  hi;
    logic [AW-1:0]  lo_w;
    logic [AW-1:0]  hi_w;
    logic [5:0]     lo_off;
    logic [5:0]     hi_off;
    logic [63:0]    mask;
    logic           target;
    logic [63:0]    wdata;
    logic [12:0]    srch_len;
    logic [12:0]    run_v;
    logic           hit_v;
    logic           stop_v;
    logic [SW-1:0]  fidx_v;

    assign biu_ext   = SW'(bits_in_use);
    assign size      = (biu_ext < SW'(MAP_BITS)) ? biu_ext : SW'(MAP_BITS);
    assign start_ext = SW'(start_reg);
    assign len_ext   = SW'(len_reg);
    assign end_sum   = start_ext + len_ext;
    assign hi        = end_sum - SW'(1);
    assign lo_w      = start_ext[AW+5:6];
    assign hi_w      = hi[AW+5:6];
    assign lo_off    = (waddr_reg == lo_w) ? start_reg[5:0] : 6'd0;
    assign hi_off    = (waddr_reg == hi_w) ? hi[5:0] : 6'd63;
    assign mask      = ({64{1'b1}} << lo_off) & ({64{1'b1}} >> (6'd63 - hi_off));
    assign target    = (req_reg == bra_pkg::REQ_MARK_USED);
    assign wdata     = target ? (rdata_reg | mask) : (rdata_reg & ~mask);
    assign srch_len  = (req_reg == bra_pkg::REQ_FIRST) ? 13'd1 : len_reg;

    // eight bits of the run scan per cycle in the scan state, paused while the next word is read and loaded
    always_comb
    begin
        logic [SW-1:0] idx;
        run_v  = run_reg;
        hit_v  = 1'b0;
        stop_v = 1'b0;
        fidx_v = '0;
        for (int j = 0; j < 8; j++)
        begin
            idx = pos_reg + SW'(j);
            if (!hit_v && !stop_v)
            begin
                if (idx >= size)
                    stop_v = 1'b1;
                else if (shift_reg[j])
                    run_v = '0;
                else
                begin
                    run_v = run_v + 13'd1;
                    if (run_v == srch_len)
                    begin
                        hit_v  = 1'b1;
                        fidx_v = idx + SW'(1) - SW'(srch_len);
                    end
                end
            end
        end
    end

    always_comb
    begin
        sts.req_type   = req_reg;
        sts.range_bad  = end_sum > size;
        sts.len_zero   = (len_reg == 13'd0);
        sts.test_in    = start_ext < size;
        sts.too_long   = len_ext > size;
        sts.last_word  = (waddr_reg == hi_w);
        sts.clear_last = (waddr_reg == AW'(WORDS - 1));
        sts.conflict   = target ? (|(rdata_reg & mask)) : (|(~rdata_reg & mask));
        sts.scan_hit   = hit_v;
        sts.scan_end   = stop_v;
        sts.word_end   = (pos_reg[5:3] == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            waddr_reg <= '0;
        else
        begin
            priority if (cmd.addr_zero)
                waddr_reg <= '0;
            else if (cmd.addr_lo)
                waddr_reg <= lo_w;
            else if (cmd.addr_inc)
                waddr_reg <= waddr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[waddr_reg] <= cmd.wr_clear ? 64'd0 : wdata;
        if (cmd.rd_en)
            rdata_reg <= mem[waddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg       <= req_type;
            start_reg     <= start_index;
            len_reg       <= run_length;
            pos_reg       <= '0;
            run_reg       <= '0;
            found_int_reg <= 1'b0;
            fidx_int_reg  <= '0;
        end
        if (cmd.set_found)
            found_int_reg <= 1'b1;
        if (cmd.shift_load)
            shift_reg <= rdata_reg;
        if (cmd.scan_step)
        begin
            shift_reg <= shift_reg >> 8;
            pos_reg   <= pos_reg + SW'(8);
            run_reg   <= run_v;
            if (hit_v)
            begin
                found_int_reg <= 1'b1;
                fidx_int_reg  <= fidx_v[11:0];
            end
        end
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            unique case (cmd.res_mode)
                bra_pkg::MODE_TEST:
                begin
                    found_reg <= 1'b0;
                    fidx_reg  <= '0;
                    bit_reg   <= rdata_reg[start_reg[5:0]];
                end
                bra_pkg::MODE_SEARCH:
                begin
                    found_reg <= found_int_reg;
                    fidx_reg  <= fidx_int_reg;
                    bit_reg   <= 1'b0;
                end
                default:
                begin
                    found_reg <= 1'b0;
                    fidx_reg  <= '0;
                    bit_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign status      = status_reg;
    assign found       = found_reg;
    assign found_index = fidx_reg;
    assign bit_value   = bit_reg;

endmodule

// ----- rtl/bra_controller.sv -----
`include "bitmap_range_allocator_core_macros.svh"

module bra_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  bra_pkg::sts_t   sts,
    output bra_pkg::cmd_t   cmd,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready
);

    bra_pkg::state_t    state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         res_status_reg, res_status_next;
    bra_pkg::res_mode_t res_mode_reg, res_mode_next;

    assign in_ready  = (state_reg == bra_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_mode_next   = res_mode_reg;
        cmd             = '0;
        cmd.res_status  = res_status_reg;
        cmd.res_mode    = res_mode_reg;
        unique case (state_reg)
            bra_pkg::S_CLEAR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_clear = 1'b1;
                if (sts.clear_last)
                begin
                    cmd.addr_zero = 1'b1;
                    state_next    = bra_pkg::S_IDLE;
                end
                else
                    cmd.addr_inc = 1'b1;
            end
            bra_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = bra_pkg::S_DISPATCH;
                end
            end
            bra_pkg::S_DISPATCH:
            begin
                res_status_next = bra_pkg::ST_OK;
                res_mode_next   = bra_pkg::MODE_NONE;
                state_next      = bra_pkg::S_DONE;
                unique case (sts.req_type)
                    bra_pkg::REQ_MARK_USED, bra_pkg::REQ_MARK_FREE:
                    begin
                        if (sts.range_bad)
                            res_status_next = bra_pkg::ST_RANGE;
                        else if (!sts.len_zero)
                        begin
                            cmd.addr_lo = 1'b1;
                            state_next  = bra_pkg::S_CHK_RD;
                        end
                    end
                    bra_pkg::REQ_TEST:
                    begin
                        if (sts.test_in)
                        begin
                            cmd.addr_lo   = 1'b1;
                            res_mode_next = bra_pkg::MODE_TEST;
                            state_next    = bra_pkg::S_TST_RD;
                        end
                    end
                    bra_pkg::REQ_FIRST:
                    begin
                        cmd.addr_zero = 1'b1;
                        res_mode_next = bra_pkg::MODE_SEARCH;
                        state_next    = bra_pkg::S_SRCH_RD;
                    end
                    bra_pkg::REQ_RUN:
                    begin
                        if (sts.len_zero)
                        begin
                            cmd.set_found = 1'b1;
                            res_mode_next = bra_pkg::MODE_SEARCH;
                        end
                        else if (!sts.too_long)
                        begin
                            cmd.addr_zero = 1'b1;
                            res_mode_next = bra_pkg::MODE_SEARCH;
                            state_next    = bra_pkg::S_SRCH_RD;
                        end
                    end
                    default:
                    begin
                        state_next = bra_pkg::S_DONE;
                    end
                endcase
            end
            bra_pkg::S_TST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = bra_pkg::S_DONE;
            end
            bra_pkg::S_CHK_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = bra_pkg::S_CHK_EV;
            end
            bra_pkg::S_CHK_EV:
            begin
                if (sts.conflict)
                begin
                    res_status_next = bra_pkg::ST_CONFLICT;
                    state_next      = bra_pkg::S_DONE;
                end
                else if (sts.last_word)
                begin
                    cmd.addr_lo = 1'b1;
                    state_next  = bra_pkg::S_WR_RD;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                    state_next   = bra_pkg::S_CHK_RD;
                end
            end
            bra_pkg::S_WR_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = bra_pkg::S_WR_EV;
            end
            bra_pkg::S_WR_EV:
            begin
                cmd.wr_en = 1'b1;
                if (sts.last_word)
                    state_next = bra_pkg::S_DONE;
                else
                begin
                    cmd.addr_inc = 1'b1;
                    state_next   = bra_pkg::S_WR_RD;
                end
            end
            bra_pkg::S_SRCH_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = bra_pkg::S_SRCH_LD;
            end
            bra_pkg::S_SRCH_LD:
            begin
                cmd.shift_load = 1'b1;
                state_next     = bra_pkg::S_SCAN;
            end
            bra_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit || sts.scan_end)
                    state_next = bra_pkg::S_DONE;
                else if (sts.word_end)
                begin
                    cmd.addr_inc = 1'b1;
                    state_next   = bra_pkg::S_SRCH_RD;
                end
            end
            bra_pkg::S_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = bra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bra_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bra_pkg::S_CLEAR;
            out_valid_reg  <= 1'b0;
            res_status_reg <= bra_pkg::ST_OK;
            res_mode_reg   <= bra_pkg::MODE_NONE;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            res_status_reg <= res_status_next;
            res_mode_reg   <= res_mode_next;
        end
    end

    `BRA_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state_reg == bra_pkg::S_DISPATCH, "accepted word not dispatched")
    `BRA_ASSERT_NEXT(a_result_shown, cmd.res_load, out_valid_reg, "loaded result not presented")
    `BRA_ASSERT_ALWAYS(a_write_state, !cmd.wr_en || state_reg == bra_pkg::S_CLEAR || state_reg == bra_pkg::S_WR_EV, "bitmap written outside clear or update")
    `BRA_ASSERT_NEXT(a_done_holds, state_reg == bra_pkg::S_DONE && out_valid_reg && !out_ready, state_reg == bra_pkg::S_DONE, "result overwrote a pending word")

endmodule

// ----- rtl/bitmap_range_allocator_core.sv -----
// First-fit bitmap allocator with one request channel and one result channel.
// A request word (req_type, start_index, run_length) is taken on in_valid &&
// in_ready; exactly one result word (status, found, found_index, bit_value)
// follows on out_valid/out_ready. Requests are served one at a time.
// Steps per request, with one memory port for reads and writes:
//   test: one word read; out-of-range, empty or unknown requests: no bitmap access;
//   mark used/free: a check pass, then an update pass, over each word spanned;
//   first free / free run: per word scanned, read, load, then 8 bits/cycle.
// Reset clears bits_in_use to 4096 and starts a clearing pass that zeroes
// the bitmap; in_ready stays low until it ends.
// A new request is accepted while the previous result still waits; when the
// receiver stalls, the finished result waits in the controller until the
// output register frees up, and no further request is taken meanwhile.
// bits_in_use is written over APB at address 0; the user must do so only
// while the block is idle, as the block itself does no such check.
module bitmap_range_allocator_core #(
    parameter int MAP_BITS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [11:0] start_index,
    input  logic [12:0] run_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        found,
    output logic [11:0] found_index,
    output logic        bit_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [12:0]   bits_in_use_reg;
    bra_pkg::cmd_t cmd;
    bra_pkg::sts_t sts;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? 32'(bits_in_use_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bits_in_use_reg <= bra_pkg::BITS_IN_USE_RESET;
        else if (psel && penable && pwrite && pready && paddr == 3'd0)
            bits_in_use_reg <= pwdata[12:0];
    end

    bra_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sts       (sts),
        .cmd       (cmd),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    bra_datapath #(
        .MAP_BITS (MAP_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .bits_in_use (bits_in_use_reg),
        .req_type    (req_type),
        .start_index (start_index),
        .run_length  (run_length),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .bit_value   (bit_value)
    );

endmodule
